// ----- src/uart_rct_pkg.sv -----
package uart_rct_pkg;

  // Action codes carried by each input beat.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_CTRL      = 3'd0;
  localparam logic [2:0] REG_TX_STATUS = 3'd1;
  localparam logic [2:0] REG_RX_STATUS = 3'd2;
  localparam logic [2:0] REG_TX_DATA   = 3'd3;
  localparam logic [2:0] REG_RX_DATA   = 3'd4;

  // Reset values.
  localparam logic [7:0] CTRL_RST      = 8'hE2;
  localparam logic [7:0] TX_STATUS_RST = 8'h01;
  localparam logic [7:0] RX_STATUS_RST = 8'h80;
  localparam logic [6:0] PRESC_RST     = 7'd1;
  localparam logic [6:0] PRESC_ALL     = 7'h7F;

  // Transmit status bits.
  localparam int unsigned TX_EN  = 7;
  localparam int unsigned TX_IE  = 6;
  localparam int unsigned TX_SB  = 4;
  localparam int unsigned TX_BRK = 3;
  localparam int unsigned TX_FRC = 2;
  localparam int unsigned TX_VAL = 1;
  localparam int unsigned TX_BE  = 0;

  // Receive status bits.
  localparam int unsigned RX_EN  = 7;
  localparam int unsigned RX_IE  = 6;
  localparam int unsigned RX_CA  = 4;
  localparam int unsigned RX_OVE = 1;

  // Write masks for the status registers and the error summary mask.
  localparam logic [7:0] TX_STATUS_WMASK = 8'hDE;
  localparam logic [7:0] TX_STATUS_KEEP  = 8'h01;
  localparam logic [7:0] RX_STATUS_WMASK = 8'hC6;
  localparam logic [7:0] RX_STATUS_KEEP  = 8'h18;
  localparam logic [7:0] RX_ERR_MASK     = 8'h0E;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic       rx_offer_valid;
    logic [7:0] rx_offer_char;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rx_offer_taken;
    logic       tx_char_valid;
    logic [7:0] tx_char;
    logic       tx_irq;
    logic       rx_irq;
  } result_t;

  // Bit times in one frame: start, 5 to 8 data bits, optional parity, 1 or 2 stop bits.
  function automatic logic [3:0] frame_bits(input logic [7:0] ctrl, input logic [7:0] tx_st);
    logic [3:0] n;
    n = 4'd6 + {2'b00, ctrl[7:6]} + {3'b000, ctrl[5]};
    n = n + (tx_st[TX_SB] ? 4'd2 : 4'd1);
    return n;
  endfunction

  // Prescaler reload chosen by the clock-mode bits.
  function automatic logic [6:0] presc_reload(input logic [7:0] ctrl);
    logic [6:0] d;
    case (ctrl[2:1])
      2'd0:    d = 7'd1;
      2'd1:    d = 7'd16;
      2'd2:    d = 7'd32;
      default: d = 7'd64;
    endcase
    return d;
  endfunction

endpackage

// ----- src/uart_rct_if.sv -----
interface uart_rct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  logic       rx_offer_valid;
  logic [7:0] rx_offer_char;

  modport source (output valid, action, reg_index, write_data, rx_offer_valid, rx_offer_char,
                  input ready);
  modport sink (input valid, action, reg_index, write_data, rx_offer_valid, rx_offer_char,
                output ready);
endinterface

interface uart_rct_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       rx_offer_taken;
  logic       tx_char_valid;
  logic [7:0] tx_char;
  logic       tx_irq;
  logic       rx_irq;

  modport source (output valid, read_data, rx_offer_taken, tx_char_valid, tx_char, tx_irq,
                  rx_irq, input ready);
  modport sink (input valid, read_data, rx_offer_taken, tx_char_valid, tx_char, tx_irq,
                rx_irq, output ready);
endinterface

// ----- src/uart_register_and_character_timing.sv -----
// Each accepted beat passes through the input register, then the result register; its
// result stays in the result register until the sink takes it.
// Throughput: one beat per cycle, limited only by the sink's ready on the result channel.
// Reset: synchronous, active low; control 0xE2, tx status 0x01, rx status 0x80, all holding,
// shift and count registers zero, prescaler one, both pipeline stages empty.
module uart_register_and_character_timing
  import uart_rct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  uart_rct_in_if.sink      in_ch,
  uart_rct_out_if.source   out_ch
);

  // Input register stage. A beat is captured here whenever the stage is empty or is handing
  // its beat on in the same cycle, so a full result register alone never stalls the input
  // side for more than the one beat it buffers.
  logic    in_vld_r;
  item_t   in_q_r;
  logic    in_ready;
  logic    advance;
  logic    proc;

  // Result register stage.
  logic    out_vld_r;
  result_t out_q_r;
  result_t res;

  // Architectural state of the UART.
  logic [7:0] ctrl_r,          ctrl_nxt;
  logic [7:0] tx_status_r,     tx_status_nxt;
  logic [7:0] rx_status_r,     rx_status_nxt;
  logic [7:0] tx_holding_r,    tx_holding_nxt;
  logic [7:0] rx_holding_r,    rx_holding_nxt;
  logic [7:0] tx_shift_char_r, tx_shift_char_nxt;
  logic [3:0] tx_bits_left_r,  tx_bits_left_nxt;
  logic [7:0] rx_shift_char_r, rx_shift_char_nxt;
  logic [3:0] rx_bits_left_r,  rx_bits_left_nxt;
  logic [6:0] presc_r,         presc_nxt;

  logic [6:0] presc_dec;
  logic [3:0] frame_len;

  // The stage in front hands its beat on when the result register is free or being emptied.
  assign advance     = !out_vld_r || out_ch.ready;
  assign proc        = in_vld_r && advance;
  assign in_ready    = !in_vld_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_q_r.action         <= in_ch.action;
      in_q_r.reg_index      <= in_ch.reg_index;
      in_q_r.write_data     <= in_ch.write_data;
      in_q_r.rx_offer_valid <= in_ch.rx_offer_valid;
      in_q_r.rx_offer_char  <= in_ch.rx_offer_char;
    end
  end

  // The frame length is always taken from the register contents as they stand before this
  // beat; neither the receiver nor the transmitter path changes the bits it depends on.
  assign frame_len = frame_bits(ctrl_r, tx_status_r);
  assign presc_dec = presc_r - 7'd1;

  // Single pass over one beat: all state updates and the result are worked out here.
  always_comb begin
    ctrl_nxt          = ctrl_r;
    tx_status_nxt     = tx_status_r;
    rx_status_nxt     = rx_status_r;
    tx_holding_nxt    = tx_holding_r;
    rx_holding_nxt    = rx_holding_r;
    tx_shift_char_nxt = tx_shift_char_r;
    tx_bits_left_nxt  = tx_bits_left_r;
    rx_shift_char_nxt = rx_shift_char_r;
    rx_bits_left_nxt  = rx_bits_left_r;
    presc_nxt         = presc_r;
    res               = '0;

    if (proc) begin
      case (in_q_r.action)
        ACT_TICK: begin
          presc_nxt = presc_dec;
          // A prescaler that wrapped through zero also counts as an expiry.
          if (presc_dec == 7'd0 || presc_dec == PRESC_ALL) begin
            // Receiver runs first: count down a frame, or take a new character when idle.
            if (rx_status_r[RX_EN]) begin
              if (rx_bits_left_r != 4'd0) begin
                rx_bits_left_nxt = rx_bits_left_r - 4'd1;
                if (rx_bits_left_r == 4'd1) begin
                  if (rx_status_r[RX_CA]) begin
                    rx_status_nxt[RX_OVE] = 1'b1;
                  end
                  rx_holding_nxt       = rx_shift_char_r;
                  rx_status_nxt[RX_CA] = 1'b1;
                end
              end else if (in_q_r.rx_offer_valid) begin
                rx_shift_char_nxt  = in_q_r.rx_offer_char;
                rx_bits_left_nxt   = frame_len;
                res.rx_offer_taken = 1'b1;
              end
            end
            // Transmitter: the countdown holds while disabled or sending break.
            if (tx_status_r[TX_EN] && !tx_status_r[TX_BRK] && tx_bits_left_r != 4'd0) begin
              tx_bits_left_nxt = tx_bits_left_r - 4'd1;
              if (tx_bits_left_r == 4'd1) begin
                res.tx_char_valid = 1'b1;
                if (tx_status_r[TX_FRC]) begin
                  res.tx_char = tx_status_r[TX_VAL] ? 8'hFF : 8'h00;
                end else begin
                  res.tx_char = tx_shift_char_r;
                end
                // Reload from the holding register when it has a character waiting.
                if (!tx_status_r[TX_BE]) begin
                  tx_shift_char_nxt    = tx_holding_r;
                  tx_bits_left_nxt     = frame_len;
                  tx_status_nxt[TX_BE] = 1'b1;
                end
              end
            end
            presc_nxt = presc_reload(ctrl_r);
          end
        end

        ACT_READ: begin
          case (in_q_r.reg_index)
            REG_CTRL:      res.read_data = ctrl_r;
            REG_TX_STATUS: res.read_data = tx_status_r;
            // The error summary bit is never stored; it reads as the OR of the error flags.
            REG_RX_STATUS: res.read_data = {rx_status_r[7:1],
                                            rx_status_r[0] | (|(rx_status_r & RX_ERR_MASK))};
            REG_TX_DATA:   res.read_data = tx_holding_r;
            REG_RX_DATA: begin
              // Reading an empty receive holding register gives zero and changes nothing.
              if (rx_status_r[RX_CA]) begin
                res.read_data        = rx_holding_r;
                rx_status_nxt[RX_CA] = 1'b0;
              end
            end
            default: res.read_data = 8'h00;
          endcase
        end

        ACT_WRITE: begin
          case (in_q_r.reg_index)
            REG_CTRL: ctrl_nxt = in_q_r.write_data;
            REG_TX_STATUS: begin
              tx_status_nxt = (tx_status_r & TX_STATUS_KEEP)
                            | (in_q_r.write_data & TX_STATUS_WMASK);
            end
            REG_RX_STATUS: begin
              rx_status_nxt = (rx_status_r & RX_STATUS_KEEP)
                            | (in_q_r.write_data & RX_STATUS_WMASK);
            end
            REG_TX_DATA: begin
              // A byte written while the holding register is full is dropped, but an idle,
              // enabled shifter still pulls in whatever the holding register contains.
              if (tx_status_r[TX_BE]) begin
                tx_holding_nxt       = in_q_r.write_data;
                tx_status_nxt[TX_BE] = 1'b0;
              end
              if (tx_status_r[TX_EN] && tx_bits_left_r == 4'd0) begin
                tx_shift_char_nxt    = tx_holding_nxt;
                tx_bits_left_nxt     = frame_len;
                tx_status_nxt[TX_BE] = 1'b1;
              end
            end
            default: ctrl_nxt = ctrl_r;
          endcase
        end

        default: res.read_data = 8'h00;
      endcase
    end

    // Interrupt levels reflect the status after this beat.
    res.tx_irq = tx_status_nxt[TX_IE] && tx_status_nxt[TX_BE];
    res.rx_irq = rx_status_nxt[RX_IE] && rx_status_nxt[RX_CA];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r          <= CTRL_RST;
      tx_status_r     <= TX_STATUS_RST;
      rx_status_r     <= RX_STATUS_RST;
      tx_holding_r    <= 8'h00;
      rx_holding_r    <= 8'h00;
      tx_shift_char_r <= 8'h00;
      tx_bits_left_r  <= 4'd0;
      rx_shift_char_r <= 8'h00;
      rx_bits_left_r  <= 4'd0;
      presc_r         <= PRESC_RST;
    end else begin
      ctrl_r          <= ctrl_nxt;
      tx_status_r     <= tx_status_nxt;
      rx_status_r     <= rx_status_nxt;
      tx_holding_r    <= tx_holding_nxt;
      rx_holding_r    <= rx_holding_nxt;
      tx_shift_char_r <= tx_shift_char_nxt;
      tx_bits_left_r  <= tx_bits_left_nxt;
      rx_shift_char_r <= rx_shift_char_nxt;
      rx_bits_left_r  <= rx_bits_left_nxt;
      presc_r         <= presc_nxt;
    end
  end

  // Result register: loaded on every processed beat, emptied when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_q_r <= res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.read_data      = out_q_r.read_data;
  assign out_ch.rx_offer_taken = out_q_r.rx_offer_taken;
  assign out_ch.tx_char_valid  = out_q_r.tx_char_valid;
  assign out_ch.tx_char        = out_q_r.tx_char;
  assign out_ch.tx_irq         = out_q_r.tx_irq;
  assign out_ch.rx_irq         = out_q_r.rx_irq;

endmodule

// ----- src/uart_rct_checker.sv -----
module uart_rct_checker
  import uart_rct_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data,
  input logic       out_rx_offer_taken,
  input logic       out_tx_char_valid,
  input logic [7:0] out_tx_char
);

  // The result channel is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present straight after reset");

  // A character is only reported with its valid flag.
  a_tx_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_char_valid |-> out_tx_char == 8'h00)
    else $error("tx_char nonzero without tx_char_valid");

  // Line activity only comes from ticks, which never carry read data.
  a_tick_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tx_char_valid || out_rx_offer_taken) |-> out_read_data == 8'h00)
    else $error("read data on a tick result");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) && $stable(out_tx_char))
    else $error("result beat changed while stalled");

endmodule

bind uart_register_and_character_timing uart_rct_checker u_uart_rct_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_read_data      (out_ch.read_data),
  .out_rx_offer_taken (out_ch.rx_offer_taken),
  .out_tx_char_valid  (out_ch.tx_char_valid),
  .out_tx_char        (out_ch.tx_char)
);

// ----- sim/uart_register_and_character_timing_tb.sv -----
`timescale 1ns / 1ps

module uart_register_and_character_timing_tb;
  import uart_rct_pkg::*;

  // The package names only the three real actions; the fourth code must be ignored.
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Register indexes beyond the five real registers.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Control register parity enable, and receive status bits the package leaves unnamed.
  localparam int unsigned CTRL_PARITY = 5;
  localparam int unsigned RX_FE       = 3;
  localparam int unsigned RX_PE       = 2;
  localparam int unsigned RX_ERR      = 0;

  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LONG_STALL    = 150;
  localparam int unsigned MAX_PAUSE     = 18;
  localparam int unsigned RANDOM_BEATS  = 1100;

  // A beat waiting to be sent. When wait_idle is set, the sender holds it back until every
  // reply already owed has come out of the block.
  typedef struct packed {
    logic  wait_idle;
    item_t beat;
  } send_entry_t;

  logic clk = 1'b1;
  logic rst_n = 1'b0;

  always begin
    #2 clk = 1'b0;
    #2 clk = 1'b1;
  end

  uart_rct_in_if  beat_in ();
  uart_rct_out_if reply_out ();

  uart_register_and_character_timing uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (beat_in),
    .out_ch (reply_out)
  );

  send_entry_t beats_to_send[$];
  result_t     replies_due[$];

  // Handshake flags from the last rising edge, read by the drivers at the falling edge.
  logic in_beat;
  logic out_beat;

  int unsigned beats_sent;
  int unsigned replies_checked;
  int unsigned mismatches;
  int unsigned chars_sent;
  int unsigned offers_taken;
  int unsigned idle_cycles;

  int unsigned src_gap;
  int unsigned src_calm;
  int unsigned snk_gap;
  int unsigned snk_calm;
  int unsigned long_left;

  // Our own copy of the UART's registers, counters and prescaler.
  logic [7:0] uart_ctrl;
  logic [7:0] uart_txs;
  logic [7:0] uart_rxs;
  logic [7:0] tx_hold;
  logic [7:0] rx_hold;
  logic [7:0] tx_shift;
  logic [7:0] rx_shift;
  logic [3:0] tx_left;
  logic [3:0] rx_left;
  logic [6:0] presc;

  // Bit times per character: a start bit, five to eight data bits, an optional parity bit
  // and one or two stop bits. It always follows the registers as they stand now.
  function automatic logic [3:0] bit_times();
    return 4'd6 + {2'b00, uart_ctrl[7:6]} + {3'b000, uart_ctrl[CTRL_PARITY]}
           + (uart_txs[TX_SB] ? 4'd2 : 4'd1);
  endfunction

  // Clock modes 1 to 3 divide by 16, 32 and 64, which are powers of two from four upwards.
  function automatic logic [6:0] tick_reload();
    if (uart_ctrl[2:1] == 2'b00) begin
      return 7'd1;
    end
    return 7'd1 << (3 + uart_ctrl[2:1]);
  endfunction

  function automatic void refill_shifter();
    tx_shift = tx_hold;
    tx_left = bit_times();
    uart_txs[TX_BE] = 1'b1;
  endfunction

  // Works out the one reply that an accepted beat causes and moves our state on.
  function automatic result_t reply_for(input item_t it);
    result_t r;
    r = '0;
    case (it.action)
      ACT_TICK: begin
        presc = presc - 7'd1;
        // The prescaler cannot sit at zero after reset, but wrapping past it still counts.
        if (presc == 7'd0 || presc == 7'h7F) begin
          // The receiver goes first: finish a character in flight, or take a new offer.
          if (uart_rxs[RX_EN]) begin
            if (rx_left != 4'd0) begin
              rx_left = rx_left - 4'd1;
              if (rx_left == 4'd0) begin
                if (uart_rxs[RX_CA]) begin
                  uart_rxs[RX_OVE] = 1'b1;
                end
                rx_hold = rx_shift;
                uart_rxs[RX_CA] = 1'b1;
              end
            end else if (it.rx_offer_valid) begin
              rx_shift = it.rx_offer_char;
              rx_left = bit_times();
              r.rx_offer_taken = 1'b1;
            end
          end
          // The transmitter counts down only when enabled and not sending a break.
          if (uart_txs[TX_EN] && !uart_txs[TX_BRK] && tx_left != 4'd0) begin
            tx_left = tx_left - 4'd1;
            if (tx_left == 4'd0) begin
              r.tx_char_valid = 1'b1;
              r.tx_char = uart_txs[TX_FRC] ? {8{uart_txs[TX_VAL]}} : tx_shift;
              if (!uart_txs[TX_BE]) begin
                refill_shifter();
              end
            end
          end
          presc = tick_reload();
        end
      end
      ACT_READ: begin
        case (it.reg_index)
          REG_CTRL:      r.read_data = uart_ctrl;
          REG_TX_STATUS: r.read_data = uart_txs;
          REG_RX_STATUS: begin
            r.read_data = uart_rxs;
            r.read_data[RX_ERR] = uart_rxs[RX_ERR] | uart_rxs[RX_FE] | uart_rxs[RX_PE]
                                  | uart_rxs[RX_OVE];
          end
          REG_TX_DATA:   r.read_data = tx_hold;
          REG_RX_DATA: begin
            // Reading an empty receive register gives zero and leaves the flags alone.
            if (uart_rxs[RX_CA]) begin
              r.read_data = rx_hold;
              uart_rxs[RX_CA] = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ACT_WRITE: begin
        case (it.reg_index)
          REG_CTRL:      uart_ctrl = it.write_data;
          // BE and bit 5 are not writable.
          REG_TX_STATUS: uart_txs = {it.write_data[7:6], uart_txs[5], it.write_data[4:1],
                                     uart_txs[TX_BE]};
          // CA and FE are kept, bit 5 and the error summary are never stored.
          REG_RX_STATUS: uart_rxs = {it.write_data[7:6], 1'b0, uart_rxs[4:3],
                                     it.write_data[2:1], 1'b0};
          REG_TX_DATA: begin
            // A write to a full holding register is lost, yet an idle shifter still reloads.
            if (uart_txs[TX_BE]) begin
              tx_hold = it.write_data;
              uart_txs[TX_BE] = 1'b0;
            end
            if (uart_txs[TX_EN] && tx_left == 4'd0) begin
              refill_shifter();
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.tx_irq = uart_txs[TX_IE] & uart_txs[TX_BE];
    r.rx_irq = uart_rxs[RX_IE] & uart_rxs[RX_CA];
    return r;
  endfunction

  task automatic push_beat(input logic [1:0] act, input logic [2:0] idx, input logic [7:0] wd,
                           input logic ov, input logic [7:0] oc, input logic drain);
    send_entry_t e;
    e.wait_idle = drain;
    e.beat.action = act;
    e.beat.reg_index = idx;
    e.beat.write_data = wd;
    e.beat.rx_offer_valid = ov;
    e.beat.rx_offer_char = oc;
    beats_to_send.push_back(e);
  endtask

  // Sender: presents the next queued beat at the falling edge and holds it until it is taken.
  // Each beat is followed by a random pause, except during calm stretches of back-to-back beats.
  always @(negedge clk) begin : source_side
    send_entry_t head;
    if (!rst_n) begin
      beat_in.valid <= 1'b0;
      beat_in.action <= ACT_TICK;
      beat_in.reg_index <= REG_CTRL;
      beat_in.write_data <= 8'h00;
      beat_in.rx_offer_valid <= 1'b0;
      beat_in.rx_offer_char <= 8'h00;
      src_gap <= 0;
      src_calm <= 0;
    end else if (!beat_in.valid || in_beat) begin
      if (src_gap != 0) begin
        beat_in.valid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (beats_to_send.size() != 0
                   && !(beats_to_send[0].wait_idle && replies_due.size() != 0)) begin
        head = beats_to_send.pop_front();
        beat_in.valid <= 1'b1;
        beat_in.action <= head.beat.action;
        beat_in.reg_index <= head.beat.reg_index;
        beat_in.write_data <= head.beat.write_data;
        beat_in.rx_offer_valid <= head.beat.rx_offer_valid;
        beat_in.rx_offer_char <= head.beat.rx_offer_char;
        if (src_calm != 0) begin
          src_calm <= src_calm - 1;
          src_gap <= 0;
        end else begin
          src_gap <= $urandom_range(0, MAX_PAUSE);
          if ($urandom_range(0, 24) == 0) begin
            src_calm <= 40;
          end
        end
      end else begin
        beat_in.valid <= 1'b0;
      end
    end
  end

  // Receiver: after each reply it draws a pause before raising ready again. Twice in the run
  // it refuses replies for a long stretch so that the block backs up and stalls its input.
  always @(negedge clk) begin : sink_side
    int unsigned pause;
    if (!rst_n) begin
      reply_out.ready <= 1'b0;
      snk_gap <= 0;
      snk_calm <= 0;
      long_left <= 0;
    end else if (long_left != 0) begin
      reply_out.ready <= 1'b0;
      long_left <= long_left - 1;
    end else if (out_beat) begin
      if (replies_checked == 300 || replies_checked == 800) begin
        reply_out.ready <= 1'b0;
        long_left <= LONG_STALL;
      end else if (snk_calm != 0) begin
        snk_calm <= snk_calm - 1;
        reply_out.ready <= 1'b1;
      end else begin
        pause = $urandom_range(0, MAX_PAUSE);
        snk_gap <= pause;
        reply_out.ready <= (pause == 0);
        if ($urandom_range(0, 24) == 0) begin
          snk_calm <= 40;
        end
      end
    end else if (snk_gap != 0) begin
      snk_gap <= snk_gap - 1;
      reply_out.ready <= (snk_gap == 1);
    end else begin
      reply_out.ready <= 1'b1;
    end
  end

  // Both channels are sampled at the rising edge. An accepted input beat is run through our
  // UART copy at once; an accepted reply is checked against the oldest reply owed.
  always @(posedge clk) begin : reply_check
    item_t   taken;
    result_t want;
    result_t got;
    logic    bad;
    if (!rst_n) begin
      uart_ctrl = CTRL_RST;
      uart_txs = TX_STATUS_RST;
      uart_rxs = RX_STATUS_RST;
      tx_hold = 8'h00;
      rx_hold = 8'h00;
      tx_shift = 8'h00;
      rx_shift = 8'h00;
      tx_left = 4'd0;
      rx_left = 4'd0;
      presc = 7'd1;
      in_beat <= 1'b0;
      out_beat <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_beat <= beat_in.valid && beat_in.ready;
      out_beat <= reply_out.valid && reply_out.ready;
      if (beat_in.valid && beat_in.ready) begin
        taken.action = beat_in.action;
        taken.reg_index = beat_in.reg_index;
        taken.write_data = beat_in.write_data;
        taken.rx_offer_valid = beat_in.rx_offer_valid;
        taken.rx_offer_char = beat_in.rx_offer_char;
        replies_due.push_back(reply_for(taken));
        beats_sent++;
      end
      if (reply_out.valid && reply_out.ready) begin
        got.read_data = reply_out.read_data;
        got.rx_offer_taken = reply_out.rx_offer_taken;
        got.tx_char_valid = reply_out.tx_char_valid;
        got.tx_char = reply_out.tx_char;
        got.tx_irq = reply_out.tx_irq;
        got.rx_irq = reply_out.rx_irq;
        replies_checked++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("reply %0d arrived with none owed: rd=%02h", replies_checked,
                     got.read_data);
          end
        end else begin
          want = replies_due.pop_front();
          if (want.tx_char_valid) begin
            chars_sent++;
          end
          if (want.rx_offer_taken) begin
            offers_taken++;
          end
          bad = (got.read_data !== want.read_data)
                || (got.rx_offer_taken !== want.rx_offer_taken)
                || (got.tx_char_valid !== want.tx_char_valid)
                || (got.tx_char !== want.tx_char)
                || (got.tx_irq !== want.tx_irq)
                || (got.rx_irq !== want.rx_irq);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("reply %0d: expected rd=%02h taken=%0b txv=%0b txc=%02h txirq=%0b rxirq=%0b",
                       replies_checked, want.read_data, want.rx_offer_taken,
                       want.tx_char_valid, want.tx_char, want.tx_irq, want.rx_irq);
              $display("reply %0d:      got rd=%02h taken=%0b txv=%0b txc=%02h txirq=%0b rxirq=%0b",
                       replies_checked, got.read_data, got.rx_offer_taken,
                       got.tx_char_valid, got.tx_char, got.tx_irq, got.rx_irq);
            end
          end
        end
      end
      // Watchdog: any handshake on either channel counts as progress.
      if ((beat_in.valid && beat_in.ready) || (reply_out.valid && reply_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat on either channel for %0d cycles", idle_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [1:0] act;
    logic [2:0] idx;
    logic [7:0] wd;
    logic       ov;
    logic [7:0] oc;
    int unsigned pick;

    // Directed opening: every register read straight after reset, including the unsupported
    // indexes and the empty receive register, then the ignored action code with all fields
    // high, ignored writes, and the write masks of both status registers.
    for (int r = REG_CTRL; r <= REG_SPARE_HI; r++) begin
      push_beat(ACT_READ, 3'(r), 8'h00, 1'b0, 8'h00, 1'b0);
    end
    push_beat(ACT_NONE, REG_SPARE_HI, 8'hFF, 1'b1, 8'hFF, 1'b0);
    push_beat(ACT_WRITE, REG_SPARE_LO, 8'hFF, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_WRITE, REG_RX_DATA, 8'hAA, 1'b0, 8'h00, 1'b0);
    // Shortest frame and no prescaling.
    push_beat(ACT_WRITE, REG_CTRL, 8'h00, 1'b0, 8'h00, 1'b0);
    // Every writable transmit status bit high, so the break flag freezes the countdown.
    push_beat(ACT_WRITE, REG_TX_STATUS, 8'hFF, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_READ, REG_TX_STATUS, 8'h00, 1'b0, 8'h00, 1'b0);
    // First byte goes straight to the shifter, the second fills holding, the third is lost.
    push_beat(ACT_WRITE, REG_TX_DATA, 8'h5A, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_WRITE, REG_TX_DATA, 8'hA5, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_WRITE, REG_TX_DATA, 8'h3C, 1'b0, 8'h00, 1'b0);
    // The second offer lands while the receiver is already busy, so it is refused.
    push_beat(ACT_TICK, REG_CTRL, 8'h00, 1'b1, 8'hFF, 1'b0);
    push_beat(ACT_TICK, REG_CTRL, 8'h00, 1'b1, 8'h00, 1'b0);
    push_beat(ACT_WRITE, REG_TX_STATUS, 8'hD6, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_WRITE, REG_RX_STATUS, 8'hFF, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_READ, REG_RX_STATUS, 8'h00, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_WRITE, REG_RX_STATUS, 8'hC0, 1'b0, 8'h00, 1'b0);
    // Longest frame and the slowest clock mode.
    push_beat(ACT_WRITE, REG_CTRL, 8'hFF, 1'b0, 8'h00, 1'b0);
    push_beat(ACT_READ, REG_CTRL, 8'h00, 1'b0, 8'h00, 1'b0);

    // The random part opens with the block drained and a fast clock mode.
    wd = 8'($urandom);
    wd[2:1] = 2'b00;
    push_beat(ACT_WRITE, REG_CTRL, wd, 1'b0, 8'h00, 1'b1);

    // Random part: mostly ticks with offers, so that characters go both ways, mixed with
    // reads that drain the receiver, transmit data writes and occasional reconfiguration.
    // Every 250 beats the sender waits for the block to drain.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      pick = $urandom_range(0, 99);
      act = ACT_TICK;
      idx = 3'($urandom);
      wd = 8'($urandom);
      ov = 1'b0;
      oc = 8'($urandom);
      if (pick < 55) begin
        ov = ($urandom_range(0, 2) != 0);
      end else if (pick < 65) begin
        act = ACT_READ;
        idx = ($urandom_range(0, 3) == 0) ? REG_RX_STATUS : REG_RX_DATA;
      end else if (pick < 72) begin
        act = ACT_READ;
      end else if (pick < 82) begin
        act = ACT_WRITE;
        idx = REG_TX_DATA;
      end else if (pick < 85) begin
        act = ACT_WRITE;
        idx = REG_TX_STATUS;
        wd[TX_EN] = ($urandom_range(0, 7) != 0);
        wd[TX_BRK] = ($urandom_range(0, 9) == 0);
      end else if (pick < 88) begin
        act = ACT_WRITE;
        idx = REG_RX_STATUS;
        wd[RX_EN] = ($urandom_range(0, 7) != 0);
      end else if (pick < 91) begin
        act = ACT_WRITE;
        idx = REG_CTRL;
        if ($urandom_range(0, 5) != 0) begin
          wd[2:1] = 2'b00;
        end
      end else if (pick < 94) begin
        act = ACT_WRITE;
        idx = 3'($urandom_range(REG_RX_DATA, REG_SPARE_HI));
      end else if (pick < 96) begin
        act = ACT_NONE;
        ov = 1'($urandom);
      end
      push_beat(act, idx, wd, ov, oc, (i % 250) == 249);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (beats_to_send.size() != 0 || beat_in.valid || replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d beats and %0d checked replies: %0d characters sent,",
             beats_sent, replies_checked, chars_sent);
    $display("%0d offers taken by the receiver, %0d mismatches", offers_taken, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
